[rtl/islip_pkg.sv]
// shared constants and types for the islip crossbar arbiter
package islip_pkg;

   localparam int FIELD_PORTS    = 8;
   localparam int IDX_W          = 3;
   localparam int PORT_COUNT_DEF = 8;

   typedef struct packed {
      logic             hit;
      logic [IDX_W-1:0] winner;
   } grant_type;

endpackage

[rtl/islip_lane.sv]
// one output port's round-robin grant lane with its own pointer
module islip_lane #(
   parameter int PORT_COUNT = islip_pkg::PORT_COUNT_DEF,
   parameter int LANE_ID    = 0
) (
   input  logic                                                clock,
   input  logic                                                reset,
   input  logic                                                advance,
   input  logic [islip_pkg::FIELD_PORTS-1:0]                   req_request_mask,
   input  logic [islip_pkg::FIELD_PORTS*islip_pkg::IDX_W-1:0]  req_request_targets,
   output islip_pkg::grant_type                                grant
);

   localparam int LANES = (PORT_COUNT < islip_pkg::FIELD_PORTS) ?
                          PORT_COUNT : islip_pkg::FIELD_PORTS;
   localparam int IW    = islip_pkg::IDX_W;

   logic [IW-1:0]                     pointer_ff;
   logic [IW-1:0]                     pointer_in;
   logic [islip_pkg::FIELD_PORTS-1:0] lane_req;
   logic [IW:0]                       scan_idx;
   logic                              found;
   logic [IW-1:0]                     winner;

   // inputs whose head-of-line item is bound for this output
   always_comb begin
      for (int i = 0; i < islip_pkg::FIELD_PORTS; i++) begin
         lane_req[i] = (i < LANES) && req_request_mask[i] &&
                       (req_request_targets[i*IW +: IW] == IW'(LANE_ID));
      end
   end

   // scan from the pointer downwards in priority so the nearest request wins
   always_comb begin
      found    = 1'b0;
      winner   = '0;
      scan_idx = '0;
      for (int k = LANES - 1; k >= 0; k--) begin
         scan_idx = {1'b0, pointer_ff} + (IW+1)'(k);
         if (scan_idx >= (IW+1)'(LANES)) begin
            scan_idx = scan_idx - (IW+1)'(LANES);
         end
         if (lane_req[scan_idx[IW-1:0]]) begin
            found  = 1'b1;
            winner = scan_idx[IW-1:0];
         end
      end
   end

   always_comb begin
      pointer_in = pointer_ff;
      if (advance && found) begin
         if (winner == IW'(LANES - 1)) begin
            pointer_in = '0;
         end else begin
            pointer_in = winner + IW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pointer_ff <= '0;
      end else begin
         pointer_ff <= pointer_in;
      end
   end

   assign grant.hit    = found;
   assign grant.winner = winner;

endmodule

[rtl/islip_merge.sv]
// merges the per-output grants into the served, matched and winner fields
module islip_merge (
   input  islip_pkg::grant_type                                grants [islip_pkg::FIELD_PORTS],
   output logic [islip_pkg::FIELD_PORTS-1:0]                   served_mask,
   output logic [islip_pkg::FIELD_PORTS-1:0]                   output_matched_mask,
   output logic [islip_pkg::FIELD_PORTS*islip_pkg::IDX_W-1:0]  output_winner
);

   always_comb begin
      served_mask         = '0;
      output_matched_mask = '0;
      output_winner       = '0;
      for (int j = 0; j < islip_pkg::FIELD_PORTS; j++) begin
         if (grants[j].hit) begin
            output_matched_mask[j]                             = 1'b1;
            served_mask[grants[j].winner]                      = 1'b1;
            output_winner[j*islip_pkg::IDX_W +: islip_pkg::IDX_W] = grants[j].winner;
         end
      end
   end

endmodule

[rtl/islip_crossbar_arbiter_core.sv]
// single-iteration islip matching core: grant lanes, merge and output skid
// an accepted result is registered in the output register, or in the skid register while the output is stalled
// throughput: one item per cycle while req_stall is low; each granting output's pointer updates in the accept cycle
// req_stall rises only when the skid register holds an item behind a stalled result
// reset (synchronous, active high) zeroes all grant pointers and empties both stages
module islip_crossbar_arbiter_core #(
   parameter int PORT_COUNT = islip_pkg::PORT_COUNT_DEF
) (
   input  logic                                                clock,
   input  logic                                                reset,
   input  logic                                                req_valid,
   output logic                                                req_stall,
   input  logic [islip_pkg::FIELD_PORTS-1:0]                   req_request_mask,
   input  logic [islip_pkg::FIELD_PORTS*islip_pkg::IDX_W-1:0]  req_request_targets,
   output logic                                                rsp_valid,
   input  logic                                                rsp_stall,
   output logic [islip_pkg::FIELD_PORTS-1:0]                   rsp_served_mask,
   output logic [islip_pkg::FIELD_PORTS-1:0]                   rsp_output_matched_mask,
   output logic [islip_pkg::FIELD_PORTS*islip_pkg::IDX_W-1:0]  rsp_output_winner
);

   localparam int LANES = (PORT_COUNT < islip_pkg::FIELD_PORTS) ?
                          PORT_COUNT : islip_pkg::FIELD_PORTS;
   localparam int FP    = islip_pkg::FIELD_PORTS;
   localparam int WW    = islip_pkg::FIELD_PORTS * islip_pkg::IDX_W;

   islip_pkg::grant_type grants [FP];

   logic          accept;
   logic [FP-1:0] new_served;
   logic [FP-1:0] new_matched;
   logic [WW-1:0] new_winner;

   logic          main_valid_ff;
   logic [FP-1:0] main_served_ff;
   logic [FP-1:0] main_matched_ff;
   logic [WW-1:0] main_winner_ff;
   logic          skid_valid_ff;
   logic [FP-1:0] skid_served_ff;
   logic [FP-1:0] skid_matched_ff;
   logic [WW-1:0] skid_winner_ff;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;

   for (genvar j = 0; j < FP; j++) begin : g_lane
      if (j < LANES) begin : g_active
         islip_lane #(
            .PORT_COUNT (PORT_COUNT),
            .LANE_ID    (j)
         ) u_lane (
            .clock               (clock),
            .reset               (reset),
            .advance             (accept),
            .req_request_mask    (req_request_mask),
            .req_request_targets (req_request_targets),
            .grant               (grants[j])
         );
      end else begin : g_unused
         assign grants[j] = '0;
      end
   end

   islip_merge u_merge (
      .grants              (grants),
      .served_mask         (new_served),
      .output_matched_mask (new_matched),
      .output_winner       (new_winner)
   );

   // control state of the output register and skid stage
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!main_valid_ff || !rsp_stall) begin
         if (skid_valid_ff) begin
            main_valid_ff <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            main_valid_ff <= accept;
         end
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      if (!main_valid_ff || !rsp_stall) begin
         if (skid_valid_ff) begin
            main_served_ff  <= skid_served_ff;
            main_matched_ff <= skid_matched_ff;
            main_winner_ff  <= skid_winner_ff;
         end else if (accept) begin
            main_served_ff  <= new_served;
            main_matched_ff <= new_matched;
            main_winner_ff  <= new_winner;
         end
      end else if (accept) begin
         skid_served_ff  <= new_served;
         skid_matched_ff <= new_matched;
         skid_winner_ff  <= new_winner;
      end
   end

   assign rsp_valid               = main_valid_ff;
   assign rsp_served_mask         = main_served_ff;
   assign rsp_output_matched_mask = main_matched_ff;
   assign rsp_output_winner       = main_winner_ff;

   // each grant serves exactly one distinct input
   a_match_count : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($countones(rsp_served_mask) == $countones(rsp_output_matched_mask)))
      else $error("served and matched counts differ");

   // skid only fills behind a held result
   a_skid_order : assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid holds an item with the output register empty");

   // a stalled result with a new item accepted must land in the skid
   a_skid_fill : assert property (@(posedge clock) disable iff (reset)
      (main_valid_ff && rsp_stall && accept) |=> skid_valid_ff)
      else $error("item lost behind a stalled result");

endmodule

[tb/testbench.sv]
// self-checking testbench for the single-iteration islip crossbar arbiter core
module testbench;

   localparam int PORT_COUNT = islip_pkg::PORT_COUNT_DEF;
   localparam int PORTS      = islip_pkg::FIELD_PORTS;
   localparam int IW         = islip_pkg::IDX_W;
   localparam int LANES      = (PORT_COUNT < PORTS) ? PORT_COUNT : PORTS;
   localparam int RANDOM_ITEMS = 1700;

   typedef struct packed {
      logic [PORTS-1:0]    served;
      logic [PORTS-1:0]    matched;
      logic [PORTS*IW-1:0] winner;
   } match_type;

   typedef struct {
      logic [PORTS-1:0]    mask;
      logic [PORTS*IW-1:0] targets;
      bit                  typed;
      match_type           res;
   } stim_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [PORTS-1:0]    req_request_mask = '0;
   logic [PORTS*IW-1:0] req_request_targets = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [PORTS-1:0]    rsp_served_mask;
   logic [PORTS-1:0]    rsp_output_matched_mask;
   logic [PORTS*IW-1:0] rsp_output_winner;

   logic [IW-1:0] grant_ptr [PORTS];
   match_type     pending_matches [$];
   stim_row_type  directed_rows [$];
   int            error_count = 0;
   int            no_gap_left = 0;

   islip_crossbar_arbiter_core #(
      .PORT_COUNT(PORT_COUNT)
   ) DUT (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_stall               (req_stall),
      .req_request_mask        (req_request_mask),
      .req_request_targets     (req_request_targets),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_served_mask         (rsp_served_mask),
      .rsp_output_matched_mask (rsp_output_matched_mask),
      .rsp_output_winner       (rsp_output_winner)
   );

   always #1 clock = ~clock;

   // one matching slot: each output scans from its pointer, grant moves pointer past winner
   function automatic void predict_match(input logic [PORTS-1:0] mask,
                                         input logic [PORTS*IW-1:0] targets,
                                         output match_type res);
      int dest [PORTS];
      bit wants [PORTS];
      int start;
      int idx;
      bit found;
      res = '0;
      for (int i = 0; i < PORTS; i++) begin
         dest[i]  = targets[IW*i +: IW];
         wants[i] = (i < LANES) && mask[i] && (dest[i] < LANES);
      end
      for (int j = 0; j < LANES; j++) begin
         start = grant_ptr[j] % PORT_COUNT;
         found = 1'b0;
         for (int k = 0; k < PORT_COUNT && !found; k++) begin
            idx = (start + k) % PORT_COUNT;
            if (idx < LANES && wants[idx] && dest[idx] == j) begin
               found                  = 1'b1;
               res.served[idx]        = 1'b1;
               res.matched[j]         = 1'b1;
               res.winner[IW*j +: IW] = idx[IW-1:0];
               grant_ptr[j]           = IW'((idx + 1) % PORT_COUNT);
            end
         end
      end
   endfunction

   task automatic add_row(input logic [PORTS-1:0] mask, input logic [PORTS*IW-1:0] targets,
                          input bit typed, input match_type res);
      stim_row_type row;
      row.mask    = mask;
      row.targets = targets;
      row.typed   = typed;
      row.res     = res;
      directed_rows.insert(directed_rows.size(), row);
   endtask

   // called at a rising edge; returns at the edge where the item was taken
   task automatic send_item(input logic [PORTS-1:0] mask, input logic [PORTS*IW-1:0] targets,
                            input bit typed, input match_type typed_res);
      int gap;
      int r;
      match_type res;
      gap = 0;
      if (no_gap_left > 0) begin
         no_gap_left--;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 5)
            no_gap_left = $urandom_range(30, 60);
         else if (r < 60)
            gap = 0;
         else if (r < 88)
            gap = $urandom_range(1, 3);
         else
            gap = $urandom_range(6, 24);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_request_mask    <= mask;
      req_request_targets <= targets;
      do @(posedge clock); while (req_stall);
      predict_match(mask, targets, res);
      pending_matches.insert(pending_matches.size(), typed ? typed_res : res);
   endtask

   task automatic check_match();
      match_type want;
      if (pending_matches.size() == 0) begin
         $display("%0t unexpected item: served %h matched %h winner %h", $time,
                  rsp_served_mask, rsp_output_matched_mask, rsp_output_winner);
         error_count++;
      end else begin
         want = pending_matches.pop_front();
         if (rsp_served_mask !== want.served) begin
            $display("%0t served_mask expected %h got %h", $time, want.served,
                     rsp_served_mask);
            error_count++;
         end
         if (rsp_output_matched_mask !== want.matched) begin
            $display("%0t output_matched_mask expected %h got %h", $time, want.matched,
                     rsp_output_matched_mask);
            error_count++;
         end
         if (rsp_output_winner !== want.winner) begin
            $display("%0t output_winner expected %h got %h", $time, want.winner,
                     rsp_output_winner);
            error_count++;
         end
      end
   endtask

   // result side: check taken items, stall in phases of random length
   initial begin
      int hold;
      int r;
      bit stall_now;
      hold      = 0;
      stall_now = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall)
            check_match();
         if (hold == 0) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
               stall_now = 1'b0;
               hold      = $urandom_range(40, 80);
            end else if (r < 65) begin
               stall_now = 1'b0;
               hold      = $urandom_range(1, 6);
            end else if (r < 92) begin
               stall_now = 1'b1;
               hold      = $urandom_range(1, 3);
            end else begin
               stall_now = 1'b1;
               hold      = $urandom_range(8, 25);
            end
         end
         rsp_stall <= stall_now;
         hold--;
      end
   end

   initial begin
      logic [PORTS-1:0]    mask;
      logic [PORTS*IW-1:0] targets;
      int                  perm [PORTS];
      int                  r;
      int                  tmp;
      int                  sw;
      int                  hot_a;
      int                  hot_b;
      match_type           none;
      none = '0;
      foreach (grant_ptr[j]) grant_ptr[j] = '0;

      // no requests at all
      add_row(8'h00, 24'hFFFFFF, 1'b1, '{8'h00, 8'h00, 24'h000000});
      // everyone wants output 0, pointer still at input 0
      add_row(8'hFF, 24'h000000, 1'b1, '{8'h01, 8'h01, 24'h000000});
      // identity permutation matches every port
      add_row(8'hFF, 24'hFAC688, 1'b1, '{8'hFF, 8'hFF, 24'hFAC688});
      add_row(8'hFF, 24'hFFFFFF, 1'b0, none);
      add_row(8'hFF, 24'hFFFFFF, 1'b0, none);
      // idle slot must leave pointers alone
      add_row(8'h00, 24'h5A5A5A, 1'b1, '{8'h00, 8'h00, 24'h000000});
      add_row(8'hFF, 24'h053977, 1'b0, none);
      for (int i = 0; i < PORTS; i++)
         add_row(PORTS'(1) << i, 24'($urandom), 1'b0, none);
      add_row(8'hAA, 24'h000000, 1'b0, none);
      add_row(8'h55, 24'hFFFFFF, 1'b0, none);
      add_row(8'h80, 24'hFFFFFF, 1'b0, none);
      add_row(8'h01, 24'h000000, 1'b0, none);
      add_row(8'hFF, 24'($urandom), 1'b0, none);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[n])
         send_item(directed_rows[n].mask, directed_rows[n].targets,
                   directed_rows[n].typed, directed_rows[n].res);

      // hold off until every result is back
      req_valid <= 1'b0;
      wait (pending_matches.size() == 0);
      @(posedge clock);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         r = $urandom_range(0, 99);
         mask    = PORTS'($urandom);
         targets = 24'($urandom);
         if (r < 25) begin
            // contention on one or two hot outputs
            if ($urandom_range(0, 1)) mask = 8'hFF;
            hot_a = $urandom_range(0, PORTS - 1);
            hot_b = $urandom_range(0, PORTS - 1);
            for (int i = 0; i < PORTS; i++)
               targets[IW*i +: IW] = IW'($urandom_range(0, 1) ? hot_a : hot_b);
         end else if (r < 40) begin
            for (int i = 0; i < PORTS; i++) perm[i] = i;
            for (int i = PORTS - 1; i > 0; i--) begin
               sw       = $urandom_range(0, i);
               tmp      = perm[i];
               perm[i]  = perm[sw];
               perm[sw] = tmp;
            end
            for (int i = 0; i < PORTS; i++)
               targets[IW*i +: IW] = IW'(perm[i]);
         end else if (r < 50) begin
            mask = PORTS'(1) << $urandom_range(0, PORTS - 1);
         end else if (r < 60) begin
            mask = '0;
         end
         send_item(mask, targets, 1'b0, none);
         if (n % 400 == 399) begin
            req_valid <= 1'b0;
            wait (pending_matches.size() == 0);
            @(posedge clock);
         end
      end

      req_valid <= 1'b0;
      wait (pending_matches.size() == 0);
      repeat (8) @(posedge clock);
      if (error_count == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

   initial begin
      #2000000;
      $display("testbench: done, errors");
      $finish;
   end

endmodule
